[sv/assert_macros.svh]
// Assertion helpers for the pan/gain block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is low
`define SPGS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define SPGS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/spgs_pkg.sv]
package spgs_pkg;

  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned COS_DEPTH_DEF = 1024;
  localparam int unsigned PAN_W         = 16;
  localparam int unsigned GAIN_W        = 18;
  localparam int unsigned SPEED_W       = 32;
  localparam int unsigned COS_W         = 18;
  localparam int unsigned DIV_ITERS     = GAIN_W / 2;
  localparam int unsigned CNT_W         = $clog2(DIV_ITERS);

  localparam logic [PAN_W-1:0]   PAN_RESET = 16'd32768;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 32'd367001600;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 32'd2621440000;
  localparam logic [SPEED_W-1:0] SPEED_SUB = 32'd10486;
  localparam logic [29:0]        DECAY_Q30 = 30'd1073634450;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [7:0]  COS_DIV [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_req_t;

  typedef enum logic [1:0] {
    J_NEXT = 2'd0,
    J_LOOP = 2'd1,
    J_LAST = 2'd2
  } jmp_t;

  typedef struct packed {
    logic spd;
    logic tgt;
    logic dmul;
    logic dsub;
    logic cmul;
    logic dini;
    logic cnt_ld;
    logic div;
    logic qfix;
    logic omul;
    logic oreg;
    jmp_t jmp;
  } ctl_t;

  localparam int unsigned NSTEPS = 10;
  localparam int unsigned STEP_W = $clog2(NSTEPS);
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t UC_SPD  = 4'd0;
  localparam step_t UC_TGT  = 4'd1;
  localparam step_t UC_DMUL = 4'd2;
  localparam step_t UC_DSUB = 4'd3;
  localparam step_t UC_CMUL = 4'd4;
  localparam step_t UC_DINI = 4'd5;
  localparam step_t UC_DIV  = 4'd6;
  localparam step_t UC_QFIX = 4'd7;
  localparam step_t UC_OMUL = 4'd8;
  localparam step_t UC_OREG = 4'd9;

  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '0;
    w.jmp = J_NEXT;
    case (s)
      UC_SPD:  w.spd = 1'b1;
      UC_TGT:  w.tgt = 1'b1;
      UC_DMUL: w.dmul = 1'b1;
      UC_DSUB: w.dsub = 1'b1;
      UC_CMUL: w.cmul = 1'b1;
      UC_DINI: begin
        w.dini   = 1'b1;
        w.cnt_ld = 1'b1;
      end
      UC_DIV: begin
        w.div = 1'b1;
        w.jmp = J_LOOP;
      end
      UC_QFIX: w.qfix = 1'b1;
      UC_OMUL: w.omul = 1'b1;
      UC_OREG: begin
        w.oreg = 1'b1;
        w.jmp  = J_LAST;
      end
      default: w.jmp = J_LAST;
    endcase
    return w;
  endfunction

endpackage

[sv/spgs_cos_rom.sv]
module spgs_cos_rom #(
  parameter int unsigned DEPTH = spgs_pkg::COS_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic [spgs_pkg::PAN_W-1:0]             pan_i,
  output logic signed [spgs_pkg::COS_W-1:0]      cos_o
);

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned HALF = DEPTH / 2;
  localparam int unsigned AW   = $clog2(HALF + 1);
  localparam int unsigned PW   = spgs_pkg::PAN_W + $clog2(DEPTH + 1);

  typedef logic [16:0] mag_t;
  typedef mag_t rom_t [HALF+1];

  function automatic mag_t cos_quarter(input logic [63:0] j);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] x;
    theta = (spgs_pkg::PI_Q30 * j) / DEPTH;
    t2 = (theta * theta) >> 30;
    r = spgs_pkg::ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      x = ((t2 * r) >> 30) / spgs_pkg::COS_DIV[k];
      r = (x > spgs_pkg::ONE_Q30) ? 64'd0 : spgs_pkg::ONE_Q30 - x;
    end
    return mag_t'((r + 64'd8192) >> 14);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int j = 0; j <= HALF; j++) begin
      t[j] = cos_quarter(64'(j));
    end
    return t;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  logic [PW-1:0] idx_prod;
  logic [IW-1:0] idx;
  logic [IW:0]   idx2;
  logic [IW:0]   refl;
  logic          neg;
  logic [AW-1:0] addr;
  mag_t          mag_r;
  logic          neg_r;

  assign idx_prod = PW'(pan_i) * PW'(DEPTH);
  assign idx      = idx_prod[spgs_pkg::PAN_W +: IW];
  assign idx2     = {idx, 1'b0};
  assign neg      = idx2 > (IW+1)'(DEPTH);
  assign refl     = neg ? ((IW+1)'(DEPTH) - {1'b0, idx}) : {1'b0, idx};
  assign addr     = refl[AW-1:0];

  always_ff @(posedge clk) begin
    mag_r <= COS_ROM[addr];
    neg_r <= neg;
  end

  assign cos_o = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

endmodule

[sv/spgs_useq.sv]
module spgs_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  logic           out_free_i,
  output logic           busy_o,
  output spgs_pkg::ctl_t ctl_o
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } sq_state_t;

  sq_state_t                    state_r, state_nxt;
  spgs_pkg::step_t              step_r, step_nxt;
  logic [spgs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  spgs_pkg::ctl_t               word;
  logic                         run;

  assign word   = spgs_pkg::ucode(step_r);
  assign run    = state_r == SQ_RUN;
  assign busy_o = run;

  always_comb begin
    ctl_o      = run ? word : '0;
    ctl_o.oreg = run && word.oreg && out_free_i;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      SQ_IDLE: begin
        if (start_i) begin
          state_nxt = SQ_RUN;
          step_nxt  = '0;
        end
      end
      SQ_RUN: begin
        if (word.cnt_ld) begin
          cnt_nxt = spgs_pkg::CNT_W'(spgs_pkg::DIV_ITERS - 1);
        end
        case (word.jmp)
          spgs_pkg::J_NEXT: step_nxt = step_r + spgs_pkg::STEP_W'(1);
          spgs_pkg::J_LOOP: begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - spgs_pkg::CNT_W'(1);
            end else begin
              step_nxt = step_r + spgs_pkg::STEP_W'(1);
            end
          end
          spgs_pkg::J_LAST: begin
            if (out_free_i) begin
              state_nxt = SQ_IDLE;
            end
          end
          default: state_nxt = SQ_IDLE;
        endcase
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[sv/spgs_lane.sv]
module spgs_lane (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  spgs_pkg::ctl_t                            ctl_i,
  input  logic                                      dbl_i,
  input  logic                                      loaded_i,
  input  logic [spgs_pkg::GAIN_W-1:0]               tgt_i,
  input  logic signed [spgs_pkg::SAMPLE_BITS-1:0]   x_i,
  output logic signed [spgs_pkg::SAMPLE_BITS-1:0]   y_o
);

  localparam int unsigned SB = spgs_pkg::SAMPLE_BITS;
  localparam int unsigned GW = spgs_pkg::GAIN_W;
  localparam int unsigned SW = spgs_pkg::SPEED_W;
  localparam int unsigned NW = GW + SW + 1;
  localparam int unsigned PW = SW + 30;
  localparam int unsigned YW = SB + GW + 1;
  localparam int unsigned QW = YW - 16;

  logic [SW-1:0]        s_r;
  logic [GW-1:0]        g_r;
  logic [GW-1:0]        t_r;
  logic [PW-1:0]        p_r;
  logic [NW-1:0]        num_r;
  logic [SW:0]          den_r;
  logic [SW:0]          rem_r;
  logic [GW-1:0]        nq_r;
  logic signed [YW-1:0] y_r;

  logic [SW:0]          s_dbl;
  logic [SW-1:0]        v;
  logic [SW+1:0]        a_sh, b_sh;
  logic                 a_ge, b_ge;
  logic [SW:0]          a_rem, b_rem;
  logic signed [YW-1:0] prod;
  logic signed [QW-1:0] q;

  assign s_dbl = dbl_i ? {s_r, 1'b0} : {1'b0, s_r};
  assign v     = p_r[PW-1:30];

  assign a_sh  = {rem_r, nq_r[GW-1]};
  assign a_ge  = a_sh >= {1'b0, den_r};
  assign a_rem = a_ge ? (SW+1)'(a_sh - {1'b0, den_r}) : a_sh[SW:0];
  assign b_sh  = {a_rem, nq_r[GW-2]};
  assign b_ge  = b_sh >= {1'b0, den_r};
  assign b_rem = b_ge ? (SW+1)'(b_sh - {1'b0, den_r}) : b_sh[SW:0];

  assign prod  = YW'(x_i) * YW'($signed({1'b0, g_r}));
  assign q     = $signed(y_r[YW-1:16]);

  always_comb begin
    if (q[QW-1:SB-1] == '0 || q[QW-1:SB-1] == '1) begin
      y_o = q[SB-1:0];
    end else if (q[QW-1]) begin
      y_o = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= spgs_pkg::SPEED_MIN;
      g_r <= '0;
    end else begin
      if (ctl_i.spd) begin
        s_r <= (s_dbl > {1'b0, spgs_pkg::SPEED_MAX}) ? spgs_pkg::SPEED_MAX : s_dbl[SW-1:0];
      end else if (ctl_i.dsub) begin
        s_r <= (v < spgs_pkg::SPEED_MIN + spgs_pkg::SPEED_SUB) ?
               spgs_pkg::SPEED_MIN : v - spgs_pkg::SPEED_SUB;
      end
      if (ctl_i.tgt && !loaded_i) begin
        g_r <= tgt_i;
      end else if (ctl_i.qfix) begin
        g_r <= nq_r + GW'(g_r < t_r && rem_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.tgt) begin
      t_r <= tgt_i;
    end
    if (ctl_i.dmul) begin
      p_r <= PW'(s_r) * PW'(spgs_pkg::DECAY_Q30);
    end
    if (ctl_i.cmul) begin
      num_r <= NW'(g_r) * NW'(s_r) + NW'({t_r, 20'b0});
      den_r <= {1'b0, s_r} + (SW+1)'(1 << 20);
    end
    if (ctl_i.dini) begin
      rem_r <= num_r[NW-1:GW];
      nq_r  <= num_r[GW-1:0];
    end else if (ctl_i.div) begin
      rem_r <= b_rem;
      nq_r  <= {nq_r[GW-3:0], a_ge, b_ge};
    end
    if (ctl_i.omul) begin
      y_r <= prod + YW'(32768);
    end
  end

endmodule

[sv/stereo_pan_gain_smoother_top.sv]
// Channel | Ports                          | Handshake
// input   | in_valid, in_stall, in_data    | request taken when valid and not stall
// output  | out_valid, out_stall, out_data | request taken when valid and not stall
// config  | cfg_we, cfg_wdata              | pan written when cfg_we is high
//
// Each request runs through ten microcode steps from acceptance to a valid result,
// the gain division step repeating until all 18 quotient bits are formed, two per pass.
// The sequencer returns to idle after the final step and takes the next request there;
// no new request is accepted while one is in progress.
// The final step holds while the output register is full and stalled.
// Synchronous reset sets speeds to 350 and pan to center, and clears gains, load flag,
// result valid flag and sequencer.
module stereo_pan_gain_smoother_top #(
  parameter int unsigned COS_TABLE_DEPTH = spgs_pkg::COS_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spgs_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output spgs_pkg::out_req_t           out_data,
  input  logic                         cfg_we,
  input  logic [spgs_pkg::PAN_W-1:0]   cfg_wdata
);

  localparam int unsigned GW = spgs_pkg::GAIN_W;
  localparam int unsigned CW = spgs_pkg::COS_W;

  spgs_pkg::in_req_t                     in_r;
  spgs_pkg::out_req_t                    out_r;
  logic                                  out_valid_r;
  logic [spgs_pkg::PAN_W-1:0]            pan_r;
  logic [spgs_pkg::PAN_W-1:0]            applied_r;
  logic                                  loaded_r;

  logic                                  accept;
  logic                                  out_free;
  logic                                  busy;
  logic                                  dbl;
  spgs_pkg::ctl_t                        ctl;
  logic signed [CW-1:0]                  cos_val;
  logic signed [CW:0]                    tl_w, tr_w;
  logic [GW-1:0]                         tl, tr;
  logic signed [spgs_pkg::SAMPLE_BITS-1:0] l_y, r_y;

  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign dbl       = pan_r != applied_r;

  assign tl_w = (CW+1)'(65536) + (CW+1)'(cos_val);
  assign tr_w = (CW+1)'(65536) - (CW+1)'(cos_val);
  assign tl   = tl_w[GW-1:0];
  assign tr   = tr_w[GW-1:0];

  spgs_useq u_useq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (accept),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctl_o      (ctl)
  );

  spgs_cos_rom #(
    .DEPTH (COS_TABLE_DEPTH)
  ) u_cos_rom (
    .clk   (clk),
    .pan_i (pan_r),
    .cos_o (cos_val)
  );

  spgs_lane u_lane_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl),
    .dbl_i    (dbl),
    .loaded_i (loaded_r),
    .tgt_i    (tl),
    .x_i      (in_r.left_in),
    .y_o      (l_y)
  );

  spgs_lane u_lane_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl),
    .dbl_i    (dbl),
    .loaded_i (loaded_r),
    .tgt_i    (tr),
    .x_i      (in_r.right_in),
    .y_o      (r_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r       <= spgs_pkg::PAN_RESET;
      applied_r   <= spgs_pkg::PAN_RESET;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pan_r <= cfg_wdata;
      end
      if (ctl.spd) begin
        applied_r <= pan_r;
      end
      if (ctl.tgt) begin
        loaded_r <= 1'b1;
      end
      if (ctl.oreg) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (ctl.oreg) begin
      out_r.left_out  <= l_y;
      out_r.right_out <= r_y;
    end
  end

endmodule

[sv/spgs_checker.sv]
`include "assert_macros.svh"

module spgs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spgs_pkg::out_req_t  out_data
);

  logic accept;
  logic out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  `SPGS_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> in_stall, "no stall after accepted request")
  `SPGS_ASSERT(a_no_instant_result, clk, rst_n, accept && out_free |=> !out_valid, "result too early")
  `SPGS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `SPGS_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `SPGS_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall, "reset did not clear")

endmodule

bind stereo_pan_gain_smoother_top spgs_checker u_spgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
